// File: rtl/core/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam logic [2:0]  LAST_BIT   = 3'd7;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_SDA_HI,
        ACT_SDA_LO,
        ACT_SDA_TX,
        ACT_SDA_ACK,
        ACT_SCL_HI,
        ACT_SCL_LO
    } t_act;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ST_SDA_HI,
        S_ST_SCL_HI,
        S_ST_SDA_LO,
        S_ST_SCL_LO,
        S_SP_SDA_LO,
        S_SP_SCL_HI,
        S_SP_SDA_HI,
        S_WR_SDA,
        S_WR_SCL_HI,
        S_WR_SCL_LO,
        S_WA_SDA,
        S_WA_SCL_HI,
        S_WA_SCL_LO,
        S_RD_REL,
        S_RD_SCL_HI,
        S_RD_SCL_LO,
        S_RA_SDA,
        S_RA_SCL_HI,
        S_RA_SCL_LO
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        t_act act;
        logic smp;
        logic last;
        logic show_rx;
        logic show_ack;
    } t_dp_cmd;

    typedef struct packed {
        logic step_ok;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/core/i2cm_ctrl.sv
`default_nettype none

module i2cm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire i2cm_pkg::t_op       i_op,
    input  wire i2cm_pkg::t_dp_stat  i_stat,
    output i2cm_pkg::t_dp_cmd        o_cmd,
    output logic                     o_in_ready
);

    i2cm_pkg::t_state r_state, n_state;
    logic [2:0]       r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2cm_pkg::S_IDLE;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_bit          = r_bit;
        o_cmd          = '0;
        o_cmd.act      = i2cm_pkg::ACT_SDA_HI;
        o_in_ready     = (r_state == i2cm_pkg::S_IDLE);
        case (r_state)
            i2cm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_bit      = '0;
                    case (i_op)
                        i2cm_pkg::OP_START: n_state = i2cm_pkg::S_ST_SDA_HI;
                        i2cm_pkg::OP_STOP:  n_state = i2cm_pkg::S_SP_SDA_LO;
                        i2cm_pkg::OP_WRITE: n_state = i2cm_pkg::S_WR_SDA;
                        i2cm_pkg::OP_READ:  n_state = i2cm_pkg::S_RD_REL;
                        default:            n_state = i2cm_pkg::S_IDLE;
                    endcase
                end
            end
            i2cm_pkg::S_ST_SDA_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_HI;
                    n_state    = i2cm_pkg::S_ST_SCL_HI;
                end
            end
            i2cm_pkg::S_ST_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    n_state    = i2cm_pkg::S_ST_SDA_LO;
                end
            end
            i2cm_pkg::S_ST_SDA_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_LO;
                    n_state    = i2cm_pkg::S_ST_SCL_LO;
                end
            end
            i2cm_pkg::S_ST_SCL_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_LO;
                    o_cmd.last = 1'b1;
                    n_state    = i2cm_pkg::S_IDLE;
                end
            end
            i2cm_pkg::S_SP_SDA_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_LO;
                    n_state    = i2cm_pkg::S_SP_SCL_HI;
                end
            end
            i2cm_pkg::S_SP_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    n_state    = i2cm_pkg::S_SP_SDA_HI;
                end
            end
            i2cm_pkg::S_SP_SDA_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_HI;
                    o_cmd.last = 1'b1;
                    n_state    = i2cm_pkg::S_IDLE;
                end
            end
            i2cm_pkg::S_WR_SDA: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_TX;
                    n_state    = i2cm_pkg::S_WR_SCL_HI;
                end
            end
            i2cm_pkg::S_WR_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    n_state    = i2cm_pkg::S_WR_SCL_LO;
                end
            end
            i2cm_pkg::S_WR_SCL_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_LO;
                    if (r_bit == i2cm_pkg::LAST_BIT) begin
                        n_state = i2cm_pkg::S_WA_SDA;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_state = i2cm_pkg::S_WR_SDA;
                    end
                end
            end
            i2cm_pkg::S_WA_SDA: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_HI;
                    n_state    = i2cm_pkg::S_WA_SCL_HI;
                end
            end
            i2cm_pkg::S_WA_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    o_cmd.smp  = 1'b1;
                    n_state    = i2cm_pkg::S_WA_SCL_LO;
                end
            end
            i2cm_pkg::S_WA_SCL_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.act      = i2cm_pkg::ACT_SCL_LO;
                    o_cmd.last     = 1'b1;
                    o_cmd.show_ack = 1'b1;
                    n_state        = i2cm_pkg::S_IDLE;
                end
            end
            i2cm_pkg::S_RD_REL: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_HI;
                    n_state    = i2cm_pkg::S_RD_SCL_HI;
                end
            end
            i2cm_pkg::S_RD_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    o_cmd.smp  = 1'b1;
                    n_state    = i2cm_pkg::S_RD_SCL_LO;
                end
            end
            i2cm_pkg::S_RD_SCL_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_LO;
                    if (r_bit == i2cm_pkg::LAST_BIT) begin
                        n_state = i2cm_pkg::S_RA_SDA;
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_state = i2cm_pkg::S_RD_SCL_HI;
                    end
                end
            end
            i2cm_pkg::S_RA_SDA: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SDA_ACK;
                    n_state    = i2cm_pkg::S_RA_SCL_HI;
                end
            end
            i2cm_pkg::S_RA_SCL_HI: begin
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    o_cmd.act  = i2cm_pkg::ACT_SCL_HI;
                    n_state    = i2cm_pkg::S_RA_SCL_LO;
                end
            end
            i2cm_pkg::S_RA_SCL_LO: begin
                if (i_stat.step_ok) begin
                    o_cmd.step    = 1'b1;
                    o_cmd.act     = i2cm_pkg::ACT_SCL_LO;
                    o_cmd.last    = 1'b1;
                    o_cmd.show_rx = 1'b1;
                    n_state       = i2cm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = i2cm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/i2cm_dp.sv
`default_nettype none

module i2cm_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire i2cm_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [i2cm_pkg::IN_DATA_W-1:0]      i_in_data,
    input  wire logic                                i_out_ready,
    output i2cm_pkg::t_dp_stat                       o_stat,
    output logic                                     o_out_valid,
    output logic [i2cm_pkg::OUT_DATA_W-1:0]          o_out_data,
    output logic                                     o_out_sample,
    output logic                                     o_out_last
);

    logic [i2cm_pkg::BYTE_W-1:0]     r_tx;
    logic [i2cm_pkg::BYTE_W-1:0]     r_line;
    logic [i2cm_pkg::BYTE_W-1:0]     r_rx;
    logic                            r_ack_out;
    logic                            r_line_ack;
    logic                            r_scl, n_scl;
    logic                            r_sda, n_sda;
    logic                            r_out_valid;
    logic [i2cm_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_sample;
    logic                            r_out_last;
    logic [i2cm_pkg::BYTE_W-1:0]     w_rx_show;
    logic                            w_ack_show;

    always_comb begin
        n_scl = r_scl;
        n_sda = r_sda;
        case (i_cmd.act)
            i2cm_pkg::ACT_SDA_HI:  n_sda = 1'b1;
            i2cm_pkg::ACT_SDA_LO:  n_sda = 1'b0;
            i2cm_pkg::ACT_SDA_TX:  n_sda = r_tx[i2cm_pkg::BYTE_W-1];
            i2cm_pkg::ACT_SDA_ACK: n_sda = r_ack_out;
            i2cm_pkg::ACT_SCL_HI:  n_scl = 1'b1;
            i2cm_pkg::ACT_SCL_LO:  n_scl = 1'b0;
            default:               n_scl = r_scl;
        endcase
    end

    assign w_rx_show  = i_cmd.show_rx ? r_rx : '0;
    assign w_ack_show = i_cmd.show_ack & r_line_ack;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tx       <= i_in_data[7:0];
            r_ack_out  <= i_in_data[8];
            r_line     <= i_in_data[16:9];
            r_line_ack <= i_in_data[17];
            r_rx       <= '0;
        end else if (i_cmd.step) begin
            if (i_cmd.act == i2cm_pkg::ACT_SDA_TX) begin
                r_tx <= {r_tx[i2cm_pkg::BYTE_W-2:0], 1'b0};
            end
            // sda is released on every sample, so the bit is the slave level
            if (i_cmd.smp) begin
                r_rx   <= {r_rx[i2cm_pkg::BYTE_W-2:0], r_line[i2cm_pkg::BYTE_W-1]};
                r_line <= {r_line[i2cm_pkg::BYTE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_data   <= {5'd0, w_ack_show, w_rx_show, n_sda, n_scl};
            r_out_sample <= i_cmd.smp;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_stat.step_ok = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_sample   = r_out_sample;
    assign o_out_last     = r_out_last;

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_pin_sequencer.sv
// I2C master pin sequencer: byte-level bus commands in, open-drain pin steps out.
// Input channel (s_axis): one word per command. tuser carries op (start, stop,
// write byte, read byte); tdata carries the byte to send, the ack level to drive
// after a read and the line levels the slave presents during the command.
// Output channel (m_axis): one word per pin step. tdata shows the SCL level and
// SDA drive after the step, the received byte on the last step of a read and the
// sampled ack on the last step of a write; tuser marks a sampling step; tlast
// marks the final step of the command.
// Step counts: start 4, stop 3, write 27, read 20. Once its word is accepted, a
// command moves to its first state, and each step is then registered into the
// output register; steps follow one per cycle while the receiver takes them.
// Commands are handled one at a time by the sequencing state machine.
// When the receiver stalls, the step in the output register holds and the state
// machine waits. Reset returns to idle with both lines released high and the
// output channel empty.
`default_nettype none

module i2c_master_pin_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // tx_byte, ack_out, line_data, line_ack, pad
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // scl, sda, rx_byte, ack_seen, pad
    output logic             m_axis_tuser,   // sample
    output logic             m_axis_tlast
);

    i2cm_pkg::t_dp_cmd  w_cmd;
    i2cm_pkg::t_dp_stat w_stat;

    i2cm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (i2cm_pkg::t_op'(s_axis_tuser)),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    i2cm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_data    (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_stat       (w_stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_sample (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again right after a command");

    a_sample_on_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0])
        else $error("sample step with scl low");

    a_rx_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:2] != 8'd0) |-> m_axis_tlast)
        else $error("received byte shown before last step");

    a_ack_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tlast && !m_axis_tuser)
        else $error("ack shown off the last step");

endmodule

`default_nettype wire

// File: tb/pin_step_monitor.sv
module pin_step_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,    // tx_byte, ack_out, line_data, line_ack, pad
    input  logic [1:0]  i_in_user,    // op
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,   // scl, sda, rx_byte, ack_seen, pad
    input  logic        i_out_user,   // sample
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ON_SDA = 1'b0;
    localparam logic ON_SCL = 1'b1;
    localparam logic LO     = 1'b0;
    localparam logic HI     = 1'b1;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       smp;
        logic [7:0] rx;
        logic       ack;
        logic       fin;
    } t_pin_step;

    t_pin_step steps_due[$];
    logic      bus_scl = 1'b1;
    logic      bus_sda = 1'b1;

    // one line changes per step; the step shows both levels afterwards
    function automatic void push_step(logic on_scl, logic lvl, logic smp, logic fin,
                                      logic [7:0] rx, logic ack);
        t_pin_step s;
        if (on_scl) bus_scl = lvl;
        else        bus_sda = lvl;
        s.scl = bus_scl;
        s.sda = bus_sda;
        s.smp = smp;
        s.rx  = rx;
        s.ack = ack;
        s.fin = fin;
        steps_due.push_back(s);
    endfunction

    function automatic void predict_command(i2cm_pkg::t_op op, logic [7:0] tx,
                                            logic ack_out, logic [7:0] line_data,
                                            logic line_ack);
        case (op)
            i2cm_pkg::OP_START: begin
                push_step(ON_SDA, HI, LO, LO, 8'h00, LO);
                push_step(ON_SCL, HI, LO, LO, 8'h00, LO);
                push_step(ON_SDA, LO, LO, LO, 8'h00, LO);
                push_step(ON_SCL, LO, LO, HI, 8'h00, LO);
            end
            i2cm_pkg::OP_STOP: begin
                push_step(ON_SDA, LO, LO, LO, 8'h00, LO);
                push_step(ON_SCL, HI, LO, LO, 8'h00, LO);
                push_step(ON_SDA, HI, LO, HI, 8'h00, LO);
            end
            i2cm_pkg::OP_WRITE: begin
                for (int i = 7; i >= 0; i--) begin
                    push_step(ON_SDA, tx[i], LO, LO, 8'h00, LO);
                    push_step(ON_SCL, HI, LO, LO, 8'h00, LO);
                    push_step(ON_SCL, LO, LO, LO, 8'h00, LO);
                end
                push_step(ON_SDA, HI, LO, LO, 8'h00, LO);
                push_step(ON_SCL, HI, HI, LO, 8'h00, LO);
                push_step(ON_SCL, LO, LO, HI, 8'h00, line_ack);
            end
            default: begin
                // SDA released while sampling, so the byte is what the slave drives
                push_step(ON_SDA, HI, LO, LO, 8'h00, LO);
                for (int i = 7; i >= 0; i--) begin
                    push_step(ON_SCL, HI, HI, LO, 8'h00, LO);
                    push_step(ON_SCL, LO, LO, LO, 8'h00, LO);
                end
                push_step(ON_SDA, ack_out, LO, LO, 8'h00, LO);
                push_step(ON_SCL, HI, LO, LO, 8'h00, LO);
                push_step(ON_SCL, LO, LO, HI, line_data, LO);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_pin_step got;
        t_pin_step want;
        if (!i_rst_n) begin
            steps_due.delete();
            bus_scl = 1'b1;
            bus_sda = 1'b1;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.scl = i_out_data[0];
                got.sda = i_out_data[1];
                got.smp = i_out_user;
                got.rx  = i_out_data[9:2];
                got.ack = i_out_data[10];
                got.fin = i_out_last;
                if (steps_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: unexpected word scl %b sda %b smp %b",
                                 $time, got.scl, got.sda, got.smp,
                                 " rx %h ack %b last %b", got.rx, got.ack, got.fin);
                    o_errors++;
                end else begin
                    want = steps_due.pop_front();
                    if (got != want) begin
                        if (o_errors < 10) begin
                            $display("%0t: step mismatch", $time);
                            $display("  exp scl %b sda %b smp %b rx %h ack %b last %b",
                                     want.scl, want.sda, want.smp, want.rx, want.ack, want.fin);
                            $display("  got scl %b sda %b smp %b rx %h ack %b last %b",
                                     got.scl, got.sda, got.smp, got.rx, got.ack, got.fin);
                        end
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_command(i2cm_pkg::t_op'(i_in_user), i_in_data[7:0], i_in_data[8],
                                i_in_data[16:9], i_in_data[17]);
        end
        o_pending <= steps_due.size();
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TARGET_WORDS = 410;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // tx_byte, ack_out, line_data, line_ack, pad
    logic [1:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // scl, sda, rx_byte, ack_seen, pad
    logic        m_axis_tuser;   // sample
    logic        m_axis_tlast;

    int   fail_count;
    int   pending_steps;
    int   sent_words = 0;
    int   idle_cycles = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic rx_hold_req = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    i2c_master_pin_sequencer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pin_step_monitor u_steps (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_errors    (fail_count),
        .o_pending   (pending_steps)
    );

    task automatic send_cmd(input i2cm_pkg::t_op op, input logic [7:0] tx,
                            input logic ack_out, input logic [7:0] line_data,
                            input logic line_ack);
        int gap;
        if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, line_ack, line_data, ack_out, tx};
        do @(posedge clk); while (!s_axis_tready);
        sent_words++;
    endtask

    task automatic send_any(input i2cm_pkg::t_op op);
        send_cmd(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_steps != 0);
    endtask

    // receiver: per-word stall, one long hold-off
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   nbytes;
        logic hold_done;
        logic drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'd0;
        s_axis_tuser  <= i2cm_pkg::OP_START;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: out-of-order commands, extreme bytes, both ack levels
        send_any(i2cm_pkg::OP_STOP);
        send_any(i2cm_pkg::OP_START);
        send_any(i2cm_pkg::OP_START);
        send_cmd(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b0);
        send_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1);
        send_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 1'b1, 8'h5A, 1'b0);
        send_cmd(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, 8'hA5, 1'b1);
        send_cmd(i2cm_pkg::OP_READ, 8'hFF, 1'b0, 8'h00, 1'b1);
        send_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b1, 8'hFF, 1'b0);
        send_cmd(i2cm_pkg::OP_READ, 8'h5A, 1'b1, 8'hA5, 1'b1);
        send_cmd(i2cm_pkg::OP_READ, 8'hA5, 1'b0, 8'h5A, 1'b0);
        send_any(i2cm_pkg::OP_STOP);
        send_any(i2cm_pkg::OP_STOP);
        send_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 8'h3C, 1'b0);
        send_cmd(i2cm_pkg::OP_WRITE, 8'hC3, 1'b1, 8'hFF, 1'b1);
        send_any(i2cm_pkg::OP_START);
        send_cmd(i2cm_pkg::OP_WRITE, 8'h81, 1'b0, 8'h7E, 1'b0);
        send_cmd(i2cm_pkg::OP_READ, 8'h7E, 1'b1, 8'h81, 1'b1);
        send_any(i2cm_pkg::OP_STOP);

        // random: mostly framed transactions, some stray commands
        while (sent_words < TARGET_WORDS) begin
            if (!hold_done && sent_words >= 100) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (!drain_done && sent_words >= 250) begin
                drain_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 9) < 8) begin
                send_any(i2cm_pkg::OP_START);
                nbytes = $urandom_range(1, 4);
                for (int b = 0; b < nbytes; b++) begin
                    if ($urandom_range(0, 9) == 0) send_any(i2cm_pkg::OP_START);
                    send_any($urandom_range(0, 2) == 0 ? i2cm_pkg::OP_READ
                                                       : i2cm_pkg::OP_WRITE);
                end
                send_any(i2cm_pkg::OP_STOP);
            end else begin
                send_any(i2cm_pkg::t_op'($urandom_range(0, 3)));
            end
        end

        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && pending_steps == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
